// ----- hw/rtl/rbv_pkg.sv -----
// ----------------------------------------------------------------------------
// rbv_pkg
// Shared types and constants for the rank bit vector block.
// ----------------------------------------------------------------------------
`default_nettype none

package rbv_pkg;

    localparam int VAL_W = 17;

    // Fraction bits of the reciprocal used to split an index into word and bit.
    localparam int RECIP_SHIFT = 24;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_RANK = 1'b1;

    typedef struct packed {
        logic             command;
        logic             bit_value;
        logic [VAL_W-1:0] query_index;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] ones_count;
        logic             error_flag;
        logic [VAL_W-1:0] stored_length;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic div;
        logic rd;
        logic shf;
        logic cnt;
        logic sum;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic short_path;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hw/rtl/rbv_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbv_ctrl
// Sequencer that steps the datapath through a push or a rank query.
// ----------------------------------------------------------------------------
`default_nettype none

module rbv_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  rbv_pkg::t_dp_status  i_status,
    output rbv_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_SHF,
        S_CNT,
        S_SUM,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    // Pushes, and queries at or past the stored length, skip the lookup.
                    n_state = i_status.short_path ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SHF;
            end
            S_SHF: begin
                o_cmd.shf = 1'b1;
                n_state   = S_CNT;
            end
            S_CNT: begin
                o_cmd.cnt = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- hw/rtl/rbv_dp.sv -----
// ----------------------------------------------------------------------------
// rbv_dp
// Word store, length and ones counters, rank arithmetic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbv_dp #(
    parameter int WORD_BITS = 64,
    parameter int MAX_WORDS = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  rbv_pkg::t_in_item    i_in_data,
    input  rbv_pkg::t_dp_cmd     i_cmd,
    output rbv_pkg::t_dp_status  o_status,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output rbv_pkg::t_out_item   o_out_data
);

    localparam int VW    = rbv_pkg::VAL_W;
    localparam int CAP   = WORD_BITS * MAX_WORDS;
    localparam int LW    = ($clog2(CAP + 1) > VW) ? $clog2(CAP + 1) : VW;
    localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int WIW   = $clog2(MAX_WORDS + 1);
    localparam int KW    = $clog2(WORD_BITS);
    localparam int UW    = $clog2(WORD_BITS + 1);
    localparam int SH    = rbv_pkg::RECIP_SHIFT;
    localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PW    = SH + VW + AW;
    localparam int NB    = (WORD_BITS + 7) / 8;

    // Memories: each entry holds a word and the count of ones before that word.
    logic [WORD_BITS-1:0] mem_word   [MAX_WORDS];
    logic [VW-1:0]        mem_before [MAX_WORDS];

    logic [LW-1:0]        r_len;
    logic [KW-1:0]        r_pos;
    logic [WIW-1:0]       r_wi;
    logic [WORD_BITS-1:0] r_cur_word;
    logic [VW-1:0]        r_before;
    logic [VW-1:0]        r_total;

    logic [VW-1:0]        r_idx;
    logic                 r_err;
    logic [VW-1:0]        r_count;
    logic [AW-1:0]        r_w;
    logic [KW-1:0]        r_k;
    logic [UW-1:0]        r_used;
    logic [WORD_BITS-1:0] r_rd_word;
    logic [VW-1:0]        r_rd_before;
    logic [WORD_BITS-1:0] r_masked;
    logic [3:0]           r_byte_cnt [NB];

    logic                 r_out_valid;
    rbv_pkg::t_out_item   r_out;

    logic                 w_full;
    logic                 w_is_push;
    logic [LW-1:0]        w_qidx;
    logic [WORD_BITS-1:0] w_new_word;
    logic [VW-1:0]        w_new_before;
    logic                 w_write;
    logic [PW-1:0]        w_prod;
    logic [VW-1:0]        w_base;
    logic [VW-1:0]        w_rem;
    logic [UW-1:0]        w_sh;
    logic [WORD_BITS-1:0] w_mask;
    logic [NB*8-1:0]      w_padded;
    logic [3:0]           w_byte_cnt [NB];
    logic [VW-1:0]        w_sum;

    assign w_full    = (r_len == LW'(CAP));
    assign w_is_push = (i_in_data.command == rbv_pkg::CMD_PUSH);
    assign w_qidx    = LW'(i_in_data.query_index);
    assign w_write   = i_cmd.capture && w_is_push && !w_full;

    // The first bit of a word starts it afresh; later bits shift in at bit 0.
    always_comb begin
        if (r_pos == '0) begin
            w_new_word   = WORD_BITS'(i_in_data.bit_value);
            w_new_before = r_total;
        end else begin
            w_new_word   = {r_cur_word[WORD_BITS-2:0], i_in_data.bit_value};
            w_new_before = r_before;
        end
    end

    assign o_status.short_path = w_is_push || (w_qidx >= r_len);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    // Word number by reciprocal multiply; exact for any index below 2^17.
    assign w_prod = PW'(r_idx) * PW'(RECIP);
    assign w_base = VW'(r_w * WORD_BITS);
    assign w_rem  = r_idx - w_base;

    // Bits in use run from used-1 down to 0; the first k of them are wanted.
    assign w_sh   = r_used - UW'(r_k);
    assign w_mask = (WORD_BITS'(1) << r_k) - WORD_BITS'(1);

    assign w_padded = (NB * 8)'(r_masked);

    always_comb begin
        for (int b = 0; b < NB; b++) begin
            w_byte_cnt[b] = '0;
            for (int j = 0; j < 8; j++) begin
                w_byte_cnt[b] = w_byte_cnt[b] + 4'(w_padded[b*8+j]);
            end
        end
    end

    always_comb begin
        w_sum = r_rd_before;
        for (int b = 0; b < NB; b++) begin
            w_sum = w_sum + VW'(r_byte_cnt[b]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            mem_word[r_wi[AW-1:0]]   <= w_new_word;
            mem_before[r_wi[AW-1:0]] <= w_new_before;
        end
        if (i_cmd.rd) begin
            r_rd_word   <= mem_word[r_w];
            r_rd_before <= mem_before[r_w];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_pos   <= '0;
            r_wi    <= '0;
            r_total <= '0;
        end else if (w_write) begin
            r_len   <= r_len + LW'(1);
            r_total <= r_total + VW'(i_in_data.bit_value);
            if (r_pos == KW'(WORD_BITS - 1)) begin
                r_pos <= '0;
                r_wi  <= r_wi + WIW'(1);
            end else begin
                r_pos <= r_pos + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_cur_word <= w_new_word;
            r_before   <= w_new_before;
        end
        if (i_cmd.capture) begin
            r_idx <= i_in_data.query_index;
            if (w_is_push) begin
                r_err   <= w_full;
                r_count <= '0;
            end else begin
                r_err   <= (w_qidx > r_len);
                r_count <= (w_qidx == r_len) ? r_total : '0;
            end
        end
        if (i_cmd.div) begin
            r_w <= w_prod[SH +: AW];
        end
        if (i_cmd.rd) begin
            r_k    <= w_rem[KW-1:0];
            r_used <= (WIW'(r_w) == r_wi) ? UW'(r_pos) : UW'(WORD_BITS);
        end
        if (i_cmd.shf) begin
            r_masked <= (r_rd_word >> w_sh) & w_mask;
        end
        if (i_cmd.cnt) begin
            r_byte_cnt <= w_byte_cnt;
        end
        if (i_cmd.sum) begin
            r_count <= w_sum;
        end
        if (i_cmd.load) begin
            r_out.ones_count    <= r_count;
            r_out.error_flag    <= r_err;
            r_out.stored_length <= r_len[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/rank_bitvector.sv -----
// ----------------------------------------------------------------------------
// rank_bitvector
// Append-only bit vector with rank queries over a word store.
// ----------------------------------------------------------------------------
// A push writes the bit into the word store in the cycle it is accepted, and
// the result is loaded into the output register once that register is free.
// A rank query whose index equals or exceeds the stored length takes the
// same short path. Any other rank query steps through a reciprocal multiply
// that splits the index into word and bit, one registered read of the word
// and its ones-before count, a shift and mask, then a two-stage popcount and
// add. One item is in work at a time; the output register lets the next item
// be accepted while a result still waits for its transfer.
`default_nettype none

module rank_bitvector #(
    parameter int WORD_BITS = 64,
    parameter int MAX_WORDS = 1024
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  rbv_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output rbv_pkg::t_out_item  o_out_data
);

    rbv_pkg::t_dp_cmd    w_cmd;
    rbv_pkg::t_dp_status w_status;

    rbv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rbv_dp #(
        .WORD_BITS (WORD_BITS),
        .MAX_WORDS (MAX_WORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- tb/sv/rank_bitvector_tb.sv -----
// ----------------------------------------------------------------------------
// rank_bitvector_tb
// Self-checking bench for the append-only bit vector with rank queries.
// A queue of pushes and rank queries feeds an input driver. Every accepted
// transfer is run through a local predictor, which keeps the count of ones
// before every bit position. Output transfers are checked field by field
// against the oldest prediction. The stimulus covers an empty vector, short
// vectors around word boundaries, a longer vector built in runs of varying
// density, and rank queries at, below and beyond the stored length.
// ----------------------------------------------------------------------------

module rank_bitvector_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 64 * 1024;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 20;
    // Neither side idles at random between these cycle numbers.
    localparam int STEADY_FROM  = 600;
    localparam int STEADY_TO    = 1600;

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_DRAIN,
        STEP_HOLD
    } t_step_kind;

    typedef struct packed {
        t_step_kind        kind;
        rbv_pkg::t_in_item item;
    } t_step;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    rbv_pkg::t_in_item  in_data = '0;
    logic               out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    rbv_pkg::t_out_item o_out_data;

    rank_bitvector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    t_step              stim_q[$];
    rbv_pkg::t_out_item pending_results[$];
    int unsigned        gen_len = 0;

    // Predictor state: ones_upto[n] is the number of ones among the first n bits.
    int unsigned ones_upto [0:CAPACITY];
    int unsigned held_bits = 0;

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned push_total = 0;
    int unsigned push_refused = 0;
    int unsigned rank_total = 0;
    int unsigned rank_refused = 0;
    logic        in_xfer = 1'b0;
    int unsigned hold_requests = 0;
    int unsigned holds_taken = 0;
    int unsigned hold_left = 0;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic rbv_pkg::t_out_item apply_item(input rbv_pkg::t_in_item it);
        rbv_pkg::t_out_item r;
        r = '0;
        if (it.command == rbv_pkg::CMD_PUSH) begin
            if (held_bits >= CAPACITY) begin
                r.error_flag = 1'b1;
            end else begin
                ones_upto[held_bits + 1] = ones_upto[held_bits] + it.bit_value;
                held_bits++;
            end
        end else begin
            if (it.query_index > held_bits)
                r.error_flag = 1'b1;
            else
                r.ones_count = rbv_pkg::VAL_W'(ones_upto[it.query_index]);
        end
        r.stored_length = rbv_pkg::VAL_W'(held_bits);
        return r;
    endfunction

    function automatic bit idle_now();
        if (cycle_count >= STEADY_FROM && cycle_count < STEADY_TO)
            return 1'b0;
        return $urandom_range(99, 0) < 21;
    endfunction

    function automatic void add_marker(input t_step_kind kind);
        t_step s;
        s = '0;
        s.kind = kind;
        stim_q.push_back(s);
    endfunction

    function automatic void add_push(input logic b);
        t_step s;
        s.kind = STEP_ITEM;
        s.item.command = rbv_pkg::CMD_PUSH;
        s.item.bit_value = b;
        s.item.query_index = rbv_pkg::VAL_W'($urandom_range(CAPACITY, 0));
        stim_q.push_back(s);
        if (gen_len < CAPACITY)
            gen_len++;
    endfunction

    function automatic void add_rank(input int unsigned idx);
        t_step s;
        s.kind = STEP_ITEM;
        s.item.command = rbv_pkg::CMD_RANK;
        s.item.bit_value = 1'($urandom_range(1, 0));
        s.item.query_index = rbv_pkg::VAL_W'(idx);
        stim_q.push_back(s);
    endfunction

    // Index choice leans on word boundaries, the end of the vector and
    // indexes past the end.
    function automatic int unsigned pick_index();
        int unsigned sel;
        int unsigned back;
        sel = $urandom_range(99, 0);
        if (sel < 40)
            return $urandom_range(gen_len, 0);
        if (sel < 60)
            return $urandom_range(gen_len / 64, 0) * 64;
        if (sel < 72)
            return gen_len;
        if (sel < 85) begin
            back = (gen_len < 70) ? gen_len : 70;
            return gen_len - $urandom_range(back, 0);
        end
        if (gen_len >= CAPACITY)
            return $urandom_range(CAPACITY, 0);
        if ($urandom_range(1, 0) == 0)
            return gen_len + 1;
        return $urandom_range(CAPACITY, gen_len + 1);
    endfunction

    // Input driver: holds a stalled transfer, otherwise takes the next step.
    always @(negedge i_clk) begin : drive_inputs
        logic              present;
        logic              hold_now;
        logic              blocked;
        rbv_pkg::t_in_item next;
        t_step             s;
        present = in_valid && !in_xfer;
        next = in_data;
        hold_now = 1'b0;
        blocked = 1'b0;
        if (i_rst_n && !present) begin
            while (!blocked && stim_q.size() != 0 && stim_q[0].kind != STEP_ITEM) begin
                if (stim_q[0].kind == STEP_HOLD) begin
                    hold_now = 1'b1;
                    s = stim_q.pop_front();
                end else if (pending_results.size() != 0) begin
                    blocked = 1'b1;
                end else begin
                    s = stim_q.pop_front();
                end
            end
            if (!blocked && stim_q.size() != 0 && !idle_now()) begin
                s = stim_q.pop_front();
                next = s.item;
                present = 1'b1;
            end
        end
        in_valid <= present;
        in_data <= next;
        if (hold_now)
            hold_requests <= hold_requests + 1;
    end

    // Output stall: random idling, or a long hold-off when the driver asks.
    always @(negedge i_clk) begin : drive_out_stall
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= idle_now();
        end
    end

    always @(posedge i_clk) begin : watch_ports
        rbv_pkg::t_out_item want;
        rbv_pkg::t_out_item got;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            in_xfer <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                got = o_out_data;
                if (pending_results.size() == 0) begin
                    report_mismatch("result transfer with nothing pending");
                end else begin
                    want = pending_results.pop_front();
                    if (got.ones_count !== want.ones_count)
                        report_mismatch($sformatf("ones_count got %0d, expected %0d",
                            got.ones_count, want.ones_count));
                    if (got.error_flag !== want.error_flag)
                        report_mismatch($sformatf("error_flag got %0b, expected %0b",
                            got.error_flag, want.error_flag));
                    if (got.stored_length !== want.stored_length)
                        report_mismatch($sformatf("stored_length got %0d, expected %0d",
                            got.stored_length, want.stored_length));
                end
            end
            in_xfer <= in_valid && !o_in_stall;
            if (in_valid && !o_in_stall) begin
                want = apply_item(in_data);
                pending_results.push_back(want);
                if (in_data.command == rbv_pkg::CMD_PUSH) begin
                    push_total++;
                    if (want.error_flag)
                        push_refused++;
                end else begin
                    rank_total++;
                    if (want.error_flag)
                        rank_refused++;
                end
            end
        end
    end

    initial begin : run_test
        int unsigned seg_left;
        int unsigned density;
        ones_upto[0] = 0;

        // Directed: empty vector, out-of-range indexes, a few bits.
        add_rank(0);
        add_rank(1);
        add_rank(CAPACITY);
        add_push(1'b1);
        add_push(1'b0);
        add_push(1'b1);
        add_push(1'b1);
        add_rank(4);
        add_rank(3);
        add_rank(1);
        add_rank(2);
        add_rank(0);
        add_rank(5);
        add_rank(CAPACITY);
        add_marker(STEP_DRAIN);

        // Short vectors: a few words, with a rank right on each new boundary.
        for (int n = 0; n < 300; n++) begin
            if (n == 150)
                add_marker(STEP_HOLD);
            if ($urandom_range(99, 0) < 60) begin
                add_push(1'($urandom_range(1, 0)));
                if (gen_len % 64 == 0)
                    add_rank(gen_len);
            end else begin
                add_rank(pick_index());
            end
        end
        add_marker(STEP_DRAIN);

        // Longer vector in runs of varying density, so that whole words
        // of zeros and of ones appear, with ranks mixed in.
        seg_left = 0;
        density = 0;
        for (int n = 0; n < 330; n++) begin
            if (n == 165)
                add_marker(STEP_HOLD);
            if (seg_left == 0) begin
                seg_left = $urandom_range(80, 1);
                density = $urandom_range(4, 0) * 25;
            end
            seg_left--;
            if ($urandom_range(99, 0) < 70)
                add_push($urandom_range(99, 0) < density);
            else
                add_rank(pick_index());
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_valid)
            @(negedge i_clk);
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("Ran %0d pushes (%0d refused when full) and %0d rank queries (%0d out of range).",
            push_total, push_refused, rank_total, rank_refused);
        $display("Vector grew to %0d bits; %0d mismatches in %0d cycles.",
            held_bits, mismatches, cycle_count);
        if (mismatches == 0) begin
            $display("PASS rank_bitvector");
        end else begin
            $display("FAIL rank_bitvector");
        end
        $finish;
    end

    // Watchdog: 1 ms, several times the slowest expected run.
    initial begin : watchdog
        #1_000_000;
        $display("FAIL rank_bitvector");
        $finish;
    end

endmodule
